// File: rtl/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg
// Types and codes shared by the 8-bit accumulator core and its memory.
// ----------------------------------------------------------------------------
package acpu_pkg;

   localparam int unsigned AddrWidth = 16;
   localparam int unsigned DataWidth = 8;

   // Item opcodes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_EXEC    = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   // Pair sources
   localparam logic [1:0] SRC_N = 2'd0;
   localparam logic [1:0] SRC_M = 2'd1;
   localparam logic [1:0] SRC_R = 2'd2;
   localparam logic [1:0] SRC_W = 2'd3;

   // Pair targets
   localparam logic [3:0] TGT_LOOP  = 4'd0;
   localparam logic [3:0] TGT_MEM   = 4'd1;
   localparam logic [3:0] TGT_R     = 4'd2;
   localparam logic [3:0] TGT_W     = 4'd3;
   localparam logic [3:0] TGT_DPAGE = 4'd4;
   localparam logic [3:0] TGT_LPAGE = 4'd5;
   localparam logic [3:0] TGT_SOUT  = 4'd6;
   localparam logic [3:0] TGT_POUT  = 4'd7;
   localparam logic [3:0] TGT_EN    = 4'd8;
   localparam logic [3:0] TGT_JUMP  = 4'd9;
   localparam logic [3:0] TGT_DLOOP = 4'd10;
   localparam logic [3:0] TGT_JNZ   = 4'd11;
   localparam logic [3:0] TGT_JZ    = 4'd12;
   localparam logic [3:0] TGT_TRAP  = 4'd13;
   localparam logic [3:0] TGT_A     = 4'd14;
   localparam logic [3:0] TGT_B     = 4'd15;

   // Slot registers
   localparam logic [1:0] SLOT_A = 2'd0;
   localparam logic [1:0] SLOT_B = 2'd1;
   localparam logic [1:0] SLOT_R = 2'd2;
   localparam logic [1:0] SLOT_W = 2'd3;

   // System operations
   localparam logic [2:0] SYS_HALT  = 3'd0;
   localparam logic [2:0] SYS_SIN   = 3'd1;
   localparam logic [2:0] SYS_SOUT  = 3'd2;
   localparam logic [2:0] SYS_CLKLO = 3'd3;
   localparam logic [2:0] SYS_CLKHI = 3'd4;
   localparam logic [2:0] SYS_READY = 3'd5;
   localparam logic [2:0] SYS_LDEC  = 3'd6;
   localparam logic [2:0] SYS_LINC  = 3'd7;

   // ALU functions
   localparam logic [3:0] ALU_A    = 4'd0;
   localparam logic [3:0] ALU_B    = 4'd1;
   localparam logic [3:0] ALU_NA   = 4'd2;
   localparam logic [3:0] ALU_NB   = 4'd3;
   localparam logic [3:0] ALU_SLA  = 4'd4;
   localparam logic [3:0] ALU_SLB  = 4'd5;
   localparam logic [3:0] ALU_SRA  = 4'd6;
   localparam logic [3:0] ALU_SRB  = 4'd7;
   localparam logic [3:0] ALU_AND  = 4'd8;
   localparam logic [3:0] ALU_OR   = 4'd9;
   localparam logic [3:0] ALU_XOR  = 4'd10;
   localparam logic [3:0] ALU_ADD  = 4'd11;
   localparam logic [3:0] ALU_CRY  = 4'd12;
   localparam logic [3:0] ALU_LT   = 4'd13;
   localparam logic [3:0] ALU_EQ   = 4'd14;
   localparam logic [3:0] ALU_GT   = 4'd15;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  parallel_in;
      logic        serial_in_bit;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       halted;
      logic       ready_flag;
      logic [7:0] port_out;
      logic       serial_out_bit;
      logic       serial_clock;
      logic [7:0] device_enable;
      logic [7:0] program_counter;
      logic [7:0] code_page;
      logic [7:0] result_value;
      logic [7:0] acc_a;
      logic [7:0] acc_b;
   } rsp_type;

   typedef struct packed {
      logic                 rd_en;
      logic                 wr_en;
      logic [AddrWidth-1:0] addr;
      logic [DataWidth-1:0] wdata;
   } mem_req_type;

endpackage

// File: rtl/accumulator_cpu_core_8bit_top.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_core_8bit_top
// 8-bit accumulator core with a 64 KiB single-port byte memory.
// ----------------------------------------------------------------------------
// Usage: each req_ beat carries an opcode (load byte, read byte, execute one
// instruction, restart) and its operands; exactly one rsp_ beat follows for
// every request, in order, carrying the read byte and a snapshot of the
// visible core state after the item.
// From acceptance to rsp_valid every item passes S_START, S_DONE and the
// output register; a read adds S_RDATA, an instruction adds S_INSN and also
// S_OPER when it fetches a literal, reads a data byte or a page-end slot.
// The single memory port sets this: opcode fetch and operand access are
// serialized through it. A new request is taken in the cycle its predecessor
// moves into the output register, so items never overlap in the core.
// The response sits in an output register; while rsp_ready is low the core
// finishes the next item and then waits with it, and req_ready stays low.
// Reset clears the core state and the handshake state but not the held
// item or response data; the memory contents are undefined until loaded.
// ----------------------------------------------------------------------------
module accumulator_cpu_core_8bit_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  acpu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output acpu_pkg::rsp_type rsp_data
);

   acpu_pkg::mem_req_type          mem_req;
   logic [acpu_pkg::DataWidth-1:0] mem_q;
   logic                           res_valid, res_take, out_free;
   acpu_pkg::rsp_type              res_data;
   logic                           rsp_valid_ff, rsp_valid_in;
   acpu_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign res_take = res_valid && out_free;

   acpu_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data),
      .mem_req   (mem_req),
      .mem_q     (mem_q)
   );

   acpu_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_q   (mem_q)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/acpu_mem.sv
// ----------------------------------------------------------------------------
// acpu_mem
// 64 KiB byte memory, one port, registered read data.
// ----------------------------------------------------------------------------
module acpu_mem (
   input  logic                          clock,
   input  acpu_pkg::mem_req_type         mem_req,
   output logic [acpu_pkg::DataWidth-1:0] mem_q
);

   logic [acpu_pkg::DataWidth-1:0] mem_array [0:(2**acpu_pkg::AddrWidth)-1];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_array[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         mem_q <= mem_array[mem_req.addr];
      end
   end

endmodule

// File: rtl/acpu_alu.sv
// ----------------------------------------------------------------------------
// acpu_alu
// Sixteen-function ALU over the A and B operand registers.
// ----------------------------------------------------------------------------
module acpu_alu (
   input  logic [3:0] func,
   input  logic [7:0] op_a,
   input  logic [7:0] op_b,
   output logic [7:0] result
);

   logic [8:0] sum;

   assign sum = {1'b0, op_a} + {1'b0, op_b};

   always_comb begin
      unique case (func)
         acpu_pkg::ALU_A:   result = op_a;
         acpu_pkg::ALU_B:   result = op_b;
         acpu_pkg::ALU_NA:  result = ~op_a;
         acpu_pkg::ALU_NB:  result = ~op_b;
         acpu_pkg::ALU_SLA: result = {op_a[6:0], 1'b0};
         acpu_pkg::ALU_SLB: result = {op_b[6:0], 1'b0};
         acpu_pkg::ALU_SRA: result = {1'b0, op_a[7:1]};
         acpu_pkg::ALU_SRB: result = {1'b0, op_b[7:1]};
         acpu_pkg::ALU_AND: result = op_a & op_b;
         acpu_pkg::ALU_OR:  result = op_a | op_b;
         acpu_pkg::ALU_XOR: result = op_a ^ op_b;
         acpu_pkg::ALU_ADD: result = sum[7:0];
         acpu_pkg::ALU_CRY: result = {7'd0, sum[8]};
         acpu_pkg::ALU_LT:  result = (op_a < op_b) ? 8'hFF : 8'h00;
         acpu_pkg::ALU_EQ:  result = (op_a == op_b) ? 8'hFF : 8'h00;
         default:           result = (op_a > op_b) ? 8'hFF : 8'h00;
      endcase
   end

endmodule

// File: rtl/acpu_core.sv
// ----------------------------------------------------------------------------
// acpu_core
// Item sequencer and register file: serves load, read and restart items and
// fetches, decodes and executes one instruction via the shared memory port.
// ----------------------------------------------------------------------------
module acpu_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  acpu_pkg::req_type              req_data,
   output logic                           res_valid,
   input  logic                           res_take,
   output acpu_pkg::rsp_type              res_data,
   output acpu_pkg::mem_req_type          mem_req,
   input  logic [acpu_pkg::DataWidth-1:0] mem_q
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_START = 6'b000010,
      S_RDATA = 6'b000100,
      S_INSN  = 6'b001000,
      S_OPER  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   acpu_pkg::req_type item_ff, item_in;
   logic [7:0] ins_ff, ins_in;
   logic [7:0] rd_ff, rd_in;
   logic [7:0] a_ff, a_in, b_ff, b_in, r_ff, r_in, roff_ff, roff_in;
   logic [7:0] sa_ff, sa_in, sb_ff, sb_in, sr_ff, sr_in;
   logic [7:0] pc_ff, pc_in, loop_ff, loop_in;
   logic [15:0] dp_ff, dp_in;
   logic [7:0] cp_ff, cp_in, dpage_ff, dpage_in, lpage_ff, lpage_in, w_ff, w_in;
   logic [7:0] sin_ff, sin_in, sout_ff, sout_in, pout_ff, pout_in, en_ff, en_in;
   logic clk_ff, clk_in, rdy_ff, rdy_in, halt_ff, halt_in;

   logic [7:0] rview, alu_v, loop_dec;
   logic       tw_en, pa_en, pb_en, pr_en, pw_en, trap_en;
   logic [3:0] tw_tgt;
   logic [7:0] tw_v, pa_v, pb_v, pr_v, pw_v, trap_pg;
   logic [1:0] src;
   logic [3:0] tgt;
   logic [15:0] slot_addr;
   logic [7:0] slot_put_v;
   logic       accept;

   assign rview    = r_ff + roff_ff;
   assign loop_dec = loop_ff - 8'd1;
   assign accept   = req_valid && req_ready;
   assign src      = mem_q[5:4];
   assign tgt      = mem_q[3:0];
   assign slot_addr = {(mem_q[2] ? lpage_ff : 8'hFF), 6'h3F, mem_q[5:4]};

   acpu_alu u_alu (
      .func   (mem_q[3:0]),
      .op_a   (a_ff),
      .op_b   (b_ff),
      .result (alu_v)
   );

   always_comb begin
      unique case (mem_q[1:0])
         acpu_pkg::SLOT_A: slot_put_v = a_ff;
         acpu_pkg::SLOT_B: slot_put_v = b_ff;
         acpu_pkg::SLOT_R: slot_put_v = rview;
         default:          slot_put_v = w_ff;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && res_take);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      res_data.read_data       = rd_ff;
      res_data.halted          = halt_ff;
      res_data.ready_flag      = rdy_ff;
      res_data.port_out        = pout_ff;
      res_data.serial_out_bit  = sout_ff[7];
      res_data.serial_clock    = clk_ff;
      res_data.device_enable   = en_ff;
      res_data.program_counter = pc_ff;
      res_data.code_page       = cp_ff;
      res_data.result_value    = rview;
      res_data.acc_a           = a_ff;
      res_data.acc_b           = b_ff;
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      ins_in   = ins_ff;
      rd_in    = rd_ff;
      a_in = a_ff;   b_in = b_ff;   r_in = r_ff;   roff_in = roff_ff;
      sa_in = sa_ff; sb_in = sb_ff; sr_in = sr_ff;
      pc_in = pc_ff; loop_in = loop_ff; dp_in = dp_ff;
      cp_in = cp_ff; dpage_in = dpage_ff; lpage_in = lpage_ff; w_in = w_ff;
      sin_in = sin_ff; sout_in = sout_ff; pout_in = pout_ff; en_in = en_ff;
      clk_in = clk_ff; rdy_in = rdy_ff; halt_in = halt_ff;
      mem_req = '0;
      tw_en = 1'b0; tw_tgt = 4'd0; tw_v = 8'd0;
      pa_en = 1'b0; pa_v = 8'd0; pb_en = 1'b0; pb_v = 8'd0;
      pr_en = 1'b0; pr_v = 8'd0; pw_en = 1'b0; pw_v = 8'd0;
      trap_en = 1'b0; trap_pg = 8'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               state_in = S_START;
            end
         end
         S_START: begin
            rd_in    = 8'd0;
            state_in = S_DONE;
            unique case (item_ff.opcode)
               acpu_pkg::OP_LOAD: begin
                  mem_req.wr_en = 1'b1;
                  mem_req.addr  = item_ff.address;
                  mem_req.wdata = item_ff.write_data;
               end
               acpu_pkg::OP_READ: begin
                  mem_req.rd_en = 1'b1;
                  mem_req.addr  = item_ff.address;
                  state_in      = S_RDATA;
               end
               acpu_pkg::OP_EXEC: begin
                  if (!halt_ff) begin
                     mem_req.rd_en = 1'b1;
                     mem_req.addr  = {cp_ff, pc_ff};
                     pc_in         = pc_ff + 8'd1;
                     state_in      = S_INSN;
                  end
               end
               default: begin
                  halt_in  = 1'b0;
                  rdy_in   = 1'b0;
                  pc_in    = 8'd0;
                  cp_in    = 8'd0;
                  dpage_in = 8'd0;
                  lpage_in = 8'hFF;
               end
            endcase
         end
         S_RDATA: begin
            rd_in    = mem_q;
            state_in = S_DONE;
         end
         S_INSN: begin
            ins_in   = mem_q;
            state_in = S_DONE;
            priority if (mem_q[7]) begin
               priority if (src == acpu_pkg::SRC_N && tgt == acpu_pkg::TGT_MEM) begin
                  // Return: resume at the saved page and offset.
                  pc_in = w_ff;
                  cp_in = dpage_ff;
               end else if (src != acpu_pkg::SRC_N && {2'b00, src} == tgt) begin
                  // Source equal to target restores the previous copy.
                  unique case (src)
                     acpu_pkg::SRC_M: begin pa_en = 1'b1; pa_v = sa_ff; end
                     acpu_pkg::SRC_R: begin pb_en = 1'b1; pb_v = sb_ff; end
                     default:         begin pr_en = 1'b1; pr_v = sr_ff; end
                  endcase
               end else begin
                  unique case (src)
                     acpu_pkg::SRC_N: begin
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = {cp_ff, pc_ff};
                        pc_in         = pc_ff + 8'd1;
                        state_in      = S_OPER;
                     end
                     acpu_pkg::SRC_M: begin
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = dp_ff;
                        state_in      = S_OPER;
                     end
                     acpu_pkg::SRC_R: begin tw_en = 1'b1; tw_tgt = tgt; tw_v = rview; end
                     default:         begin tw_en = 1'b1; tw_tgt = tgt; tw_v = w_ff; end
                  endcase
               end
            end else if (mem_q[6]) begin
               mem_req.addr = slot_addr;
               if (mem_q[3]) begin
                  mem_req.wr_en = 1'b1;
                  mem_req.wdata = slot_put_v;
               end else begin
                  mem_req.rd_en = 1'b1;
                  state_in      = S_OPER;
               end
            end else if (mem_q[5]) begin
               trap_en = 1'b1;
               trap_pg = {3'd0, mem_q[4:0]};
            end else if (mem_q[4]) begin
               pr_en = 1'b1;
               pr_v  = alu_v;
            end else if (mem_q[3]) begin
               roff_in = {{5{mem_q[2]}}, mem_q[2:0]};
            end else begin
               unique case (mem_q[2:0])
                  acpu_pkg::SYS_HALT:  halt_in = 1'b1;
                  acpu_pkg::SYS_SIN:   sin_in = {sin_ff[6:0], item_ff.serial_in_bit};
                  acpu_pkg::SYS_SOUT:  sout_in = {sout_ff[6:0], 1'b0};
                  acpu_pkg::SYS_CLKLO: clk_in = 1'b0;
                  acpu_pkg::SYS_CLKHI: clk_in = 1'b1;
                  acpu_pkg::SYS_READY: rdy_in = 1'b1;
                  acpu_pkg::SYS_LDEC:  lpage_in = lpage_ff - 8'd1;
                  default:             lpage_in = lpage_ff + 8'd1;
               endcase
            end
         end
         S_OPER: begin
            state_in = S_DONE;
            if (ins_ff[7]) begin
               tw_en  = 1'b1;
               tw_tgt = ins_ff[3:0];
               tw_v   = mem_q;
            end else begin
               unique case (ins_ff[1:0])
                  acpu_pkg::SLOT_A: begin pa_en = 1'b1; pa_v = mem_q; end
                  acpu_pkg::SLOT_B: begin pb_en = 1'b1; pb_v = mem_q; end
                  acpu_pkg::SLOT_R: begin pr_en = 1'b1; pr_v = mem_q; end
                  default:          begin pw_en = 1'b1; pw_v = mem_q; end
               endcase
            end
         end
         default: begin
            // S_DONE: hold until the output register takes the beat.
            if (res_take) begin
               if (accept) begin
                  item_in  = req_data;
                  state_in = S_START;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase

      if (tw_en) begin
         unique case (tw_tgt)
            acpu_pkg::TGT_LOOP: loop_in = tw_v;
            acpu_pkg::TGT_MEM: begin
               mem_req.wr_en = 1'b1;
               mem_req.addr  = dp_ff;
               mem_req.wdata = tw_v;
            end
            acpu_pkg::TGT_R:     begin pr_en = 1'b1; pr_v = tw_v; end
            acpu_pkg::TGT_W:     w_in = tw_v;
            acpu_pkg::TGT_DPAGE: dpage_in = tw_v;
            acpu_pkg::TGT_LPAGE: lpage_in = tw_v;
            acpu_pkg::TGT_SOUT:  sout_in = tw_v;
            acpu_pkg::TGT_POUT: begin
               pout_in = tw_v;
               rdy_in  = 1'b1;
               halt_in = 1'b1;
            end
            acpu_pkg::TGT_EN:   en_in = tw_v;
            acpu_pkg::TGT_JUMP: pc_in = tw_v;
            acpu_pkg::TGT_DLOOP: begin
               loop_in = loop_dec;
               if (loop_dec != 8'd0) begin
                  pc_in = tw_v;
               end
            end
            acpu_pkg::TGT_JNZ: if (rview != 8'd0) pc_in = tw_v;
            acpu_pkg::TGT_JZ:  if (rview == 8'd0) pc_in = tw_v;
            acpu_pkg::TGT_TRAP: begin trap_en = 1'b1; trap_pg = tw_v; end
            acpu_pkg::TGT_A:    begin pa_en = 1'b1; pa_v = tw_v; end
            default:            begin pb_en = 1'b1; pb_v = tw_v; end
         endcase
      end

      // A trap saves the return offset in W, then switches pages.
      if (trap_en) begin
         pw_en    = 1'b1;
         pw_v     = pc_ff;
         pc_in    = 8'd0;
         dpage_in = cp_ff;
         cp_in    = trap_pg;
      end
      if (pa_en) begin
         sa_in = a_ff;
         a_in  = pa_v;
         dp_in = {dpage_ff, pa_v};
      end
      if (pb_en) begin
         sb_in = b_ff;
         b_in  = pb_v;
         dp_in = {dpage_ff, pb_v};
      end
      if (pr_en) begin
         sr_in   = rview;
         r_in    = pr_v;
         roff_in = 8'd0;
      end
      if (pw_en) begin
         w_in  = pw_v;
         dp_in = {dpage_ff, pw_v};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         a_ff <= 8'd0;  b_ff <= 8'd0;  r_ff <= 8'd0;  roff_ff <= 8'd0;
         sa_ff <= 8'd0; sb_ff <= 8'd0; sr_ff <= 8'd0;
         pc_ff <= 8'd0; loop_ff <= 8'd0; dp_ff <= 16'd0;
         cp_ff <= 8'd0; dpage_ff <= 8'd0; lpage_ff <= 8'hFF; w_ff <= 8'd0;
         sin_ff <= 8'd0; sout_ff <= 8'd0; pout_ff <= 8'd0; en_ff <= 8'd0;
         clk_ff <= 1'b0; rdy_ff <= 1'b0; halt_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         a_ff <= a_in;   b_ff <= b_in;   r_ff <= r_in;   roff_ff <= roff_in;
         sa_ff <= sa_in; sb_ff <= sb_in; sr_ff <= sr_in;
         pc_ff <= pc_in; loop_ff <= loop_in; dp_ff <= dp_in;
         cp_ff <= cp_in; dpage_ff <= dpage_in; lpage_ff <= lpage_in; w_ff <= w_in;
         sin_ff <= sin_in; sout_ff <= sout_in; pout_ff <= pout_in; en_ff <= en_in;
         clk_ff <= clk_in; rdy_ff <= rdy_in; halt_ff <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ins_ff  <= ins_in;
      rd_ff   <= rd_in;
   end

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("memory read and write in the same cycle");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_START))
      else $error("accepted beat did not start processing");

   a_oper_after_insn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OPER) |-> ($past(state_ff) == S_INSN))
      else $error("operand phase without a decoded instruction");

   a_halt_freezes_pc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START && item_ff.opcode == acpu_pkg::OP_EXEC && halt_ff)
      |=> $stable(pc_ff))
      else $error("halted core advanced its program counter");

endmodule
